FILE: rtl/gble_pkg.sv
// Shared definitions for the gap buffer line editor.
// Operation and status codes, the result record and default sizes.
// No dependencies.
package gble_pkg;

   localparam int STORE_DEPTH_DEF = 4096;

   typedef enum logic [2:0] {
      FUNC_INSERT    = 3'd0,
      FUNC_LEFT      = 3'd1,
      FUNC_RIGHT     = 3'd2,
      FUNC_BACKSPACE = 3'd3,
      FUNC_READ      = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NOP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  char_out;
      status_type  status;
      logic [12:0] cursor_pos;
      logic [12:0] text_length;
   } result_type;

endpackage

FILE: rtl/gble_ram.sv
// Generic single-clock RAM, one write port and one read port.
// Read data is registered. No dependencies.
module gble_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gap_buffer_line_editor.sv
// Gap buffer line editor: top level, control and count registers.
// Depends on gble_pkg and gble_ram.
//
// Requests arrive on req_* (valid/ready): req_func selects insert, cursor
// left, cursor right, backspace or read at req_position; req_char_in is the
// byte to insert. Every request gives one response on rsp_* (valid/ready):
// the byte read, a status, the cursor position and the text length after
// the operation.
// Insert, backspace and every operation that does nothing respond one cycle
// after acceptance, and a new request may be taken in the next cycle.
// Cursor moves and reads first read the store (read data is registered),
// then write the moved byte back across the gap in S_MOVE or capture the
// read byte in S_FETCH; no request is taken meanwhile. Throughput is one
// request per cycle for the short operations while the receiver keeps up.
// Reset clears the cursor and both counts, giving an empty line at once;
// the store needs no clearing pass.
// The response sits in an output register. A finished result that cannot
// enter it while the receiver stalls is parked, and no further request is
// taken until it has moved on.
module gap_buffer_line_editor
   import gble_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_char_in,
   input  logic [11:0] req_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_out,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_cursor_pos,
   output logic [12:0] rsp_text_length
);

   localparam int AW   = $clog2(STORE_DEPTH);
   localparam int CW   = $clog2(STORE_DEPTH + 1);
   localparam int CMPW = ((CW > 12) ? CW : 12) + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_MOVE, S_FETCH, S_HOLD} state_type;

   function automatic logic [12:0] ext13(input logic [CW-1:0] v);
      logic [CW+12:0] t;
      t = {13'b0, v};
      return t[12:0];
   endfunction

   state_type     state_ff, state_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] right_ff, right_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   result_type    pend_ff, pend_in;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   logic          accept, slot_free, fin;
   result_type    fin_res;
   logic [CW:0]   total_w;
   logic          full;
   logic [CW-1:0] left_dec, gap, top_rd, top_wr;
   logic [CMPW-1:0] pos_x, left_x, total_x, rd_sum;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign total_w  = {1'b0, left_ff} + {1'b0, right_ff};
   assign full     = total_w >= (CW + 1)'(STORE_DEPTH);
   assign left_dec = left_ff - 1'b1;
   assign gap      = DEPTH_C - total_w[CW-1:0];
   assign top_rd   = DEPTH_C - right_ff;
   assign top_wr   = top_rd - 1'b1;
   assign pos_x    = CMPW'(req_position);
   assign left_x   = CMPW'(left_ff);
   assign total_x  = CMPW'(total_w);
   assign rd_sum   = pos_x + CMPW'(gap);

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      right_in = right_ff;
      waddr_in = waddr_ff;
      pend_in  = pend_ff;
      wr_en    = 1'b0;
      wr_addr  = waddr_ff;
      wr_data  = rd_data;
      rd_en    = 1'b0;
      rd_addr  = left_dec[AW-1:0];
      fin      = 1'b0;
      fin_res.char_out = 8'd0;
      fin_res.status   = ST_NOP;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_INSERT: begin
                     fin = 1'b1;
                     if (full) begin
                        fin_res.status = ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = left_ff[AW-1:0];
                        wr_data        = req_char_in;
                        left_in        = CW'(left_ff + 1'b1);
                        fin_res.status = ST_DONE;
                     end
                  end
                  FUNC_LEFT: begin
                     if (left_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = left_dec[AW-1:0];
                        waddr_in = top_wr[AW-1:0];
                        left_in  = left_dec;
                        right_in = CW'(right_ff + 1'b1);
                        state_in = S_MOVE;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  FUNC_RIGHT: begin
                     if (right_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = top_rd[AW-1:0];
                        waddr_in = left_ff[AW-1:0];
                        left_in  = CW'(left_ff + 1'b1);
                        right_in = CW'(right_ff - 1'b1);
                        state_in = S_MOVE;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  FUNC_BACKSPACE: begin
                     fin = 1'b1;
                     if (left_ff != '0) begin
                        left_in        = left_dec;
                        fin_res.status = ST_DONE;
                     end
                  end
                  FUNC_READ: begin
                     if (pos_x < left_x) begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_x[AW-1:0];
                        state_in = S_FETCH;
                     end else if (pos_x < total_x) begin
                        rd_en    = 1'b1;
                        rd_addr  = rd_sum[AW-1:0];
                        state_in = S_FETCH;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // byte read last cycle crosses the gap
            wr_en          = 1'b1;
            wr_addr        = waddr_ff;
            wr_data        = rd_data;
            fin            = 1'b1;
            fin_res.status = ST_DONE;
         end
         S_FETCH: begin
            fin              = 1'b1;
            fin_res.char_out = rd_data;
            fin_res.status   = ST_DONE;
         end
         S_HOLD: begin
            fin     = 1'b1;
            fin_res.char_out = pend_ff.char_out;
            fin_res.status   = pend_ff.status;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      fin_res.cursor_pos  = ext13(left_in);
      fin_res.text_length = ext13(CW'(left_in + right_in));
      if (state_ff == S_HOLD) begin
         fin_res = pend_ff;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fin) begin
         if (slot_free) begin
            rsp_in       = fin_res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            pend_in  = fin_res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      waddr_ff <= waddr_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   gble_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_ff.char_out;
   assign rsp_status      = rsp_ff.status;
   assign rsp_cursor_pos  = rsp_ff.cursor_pos;
   assign rsp_text_length = rsp_ff.text_length;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE) || rsp_valid_ff)
      else $error("accepted request produced no response and no work");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      total_w <= (CW + 1)'(STORE_DEPTH))
      else $error("text length exceeds store depth");

   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff)
      else $error("result parked while output register empty");

   a_char_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_DONE)) |-> (rsp_ff.char_out == 8'd0))
      else $error("character returned with a non-done status");

endmodule
